### hdl/krt_pkg.sv
package krt_pkg;

   localparam int Depth = 256;
   localparam int IdxW  = 8;
   localparam int CntW  = 9;
   localparam int EntW  = 64 + 64 + 32 + 64 + 32 + 32 + 32;

   localparam logic [2:0] FuncUpsert = 3'd0;
   localparam logic [2:0] FuncRemove = 3'd1;
   localparam logic [2:0] FuncFind   = 3'd2;
   localparam logic [2:0] FuncReadAt = 3'd3;
   localparam logic [2:0] FuncClear  = 3'd4;

   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatMissing = 2'd1;
   localparam logic [1:0] StatFull    = 2'd2;

   typedef struct packed {
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [31:0] version;
      logic [63:0] size;
      logic [31:0] crc;
      logic [31:0] installed;
      logic [15:0] flags;
      logic [15:0] kind;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic            load_req;
      logic            rd_en;
      logic [IdxW-1:0] rd_addr;
      logic            wr_en;
      logic            wr_from_req;
      logic [IdxW-1:0] wr_addr;
      logic            cap_entry;
      logic            zero_entry;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0]      func;
      logic [IdxW-1:0] index;
      logic            key_match;
   } dp_stat_type;

endpackage

### hdl/krt_ram.sv
module krt_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/krt_datapath.sv
module krt_datapath import krt_pkg::*; (
   input  logic        clock,
   input  dp_cmd_type  cmd,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_index,
   input  logic [63:0] req_key_hi,
   input  logic [63:0] req_key_lo,
   input  logic [31:0] req_version,
   input  logic [63:0] req_package_size,
   input  logic [31:0] req_payload_crc,
   input  logic [31:0] req_installed_time,
   input  logic [15:0] req_kind,
   input  logic [15:0] req_flags,
   output dp_stat_type stat,
   output entry_type   out_entry
);

   logic [2:0]      func_ff;
   logic [IdxW-1:0] index_ff;
   entry_type       req_ff;
   entry_type       rd_entry;
   entry_type       wr_entry;
   entry_type       out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         req_ff   <= '{key_hi: req_key_hi, key_lo: req_key_lo, version: req_version,
                       size: req_package_size, crc: req_payload_crc,
                       installed: req_installed_time, flags: req_flags,
                       kind: req_kind};
      end
      if (cmd.zero_entry) begin
         out_ff <= '0;
      end else if (cmd.cap_entry) begin
         out_ff <= cmd.wr_from_req ? req_ff : rd_entry;
      end
   end

   assign wr_entry = cmd.wr_from_req ? req_ff : rd_entry;

   krt_ram #(.Width(EntW), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_entry)
   );

   assign stat.func      = func_ff;
   assign stat.index     = index_ff;
   assign stat.key_match = (rd_entry.key_hi == req_ff.key_hi) &&
                           (rd_entry.key_lo == req_ff.key_lo);
   assign out_entry      = out_ff;

endmodule

### hdl/krt_ctrl.sv
module krt_ctrl import krt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [IdxW-1:0] rsp_slot,
   output logic [CntW-1:0] rsp_live_count,
   output dp_cmd_type      cmd,
   input  dp_stat_type     stat
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_SCAN, ST_HIT, ST_SHIFT, ST_SHIFT_WR, ST_RESP
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] ptr_ff, ptr_in;     // slot whose read data is valid next
   logic [1:0]      status_ff, status_in;
   logic [IdxW-1:0] slot_ff, slot_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_live_count = count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ptr_in   = '0;
            status_in = StatMissing;
            slot_in   = '0;
            cmd.zero_entry = 1'b1;
            case (stat.func)
               FuncUpsert, FuncRemove, FuncFind: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = '0;
                  state_in    = ST_SCAN;
               end
               FuncReadAt: begin
                  if ({1'b0, stat.index} < count_ff) begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = stat.index;
                     ptr_in      = {1'b0, stat.index};
                     state_in    = ST_HIT;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               FuncClear: begin
                  count_in  = '0;
                  status_in = StatOk;
                  state_in  = ST_RESP;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_SCAN: begin
            // read data of slot ptr_ff is present
            if (ptr_ff >= count_ff) begin
               if (stat.func == FuncUpsert) begin
                  if (count_ff == CntW'(Depth)) begin
                     status_in = StatFull;
                  end else begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_from_req = 1'b1;
                     cmd.wr_addr     = ptr_ff[IdxW-1:0];
                     cmd.cap_entry   = 1'b1;
                     count_in        = count_ff + 1'b1;
                     status_in       = StatOk;
                     slot_in         = ptr_ff[IdxW-1:0];
                  end
               end
               state_in = ST_RESP;
            end else if (stat.key_match) begin
               status_in = StatOk;
               slot_in   = ptr_ff[IdxW-1:0];
               if (stat.func == FuncUpsert) begin
                  cmd.wr_en       = 1'b1;
                  cmd.wr_from_req = 1'b1;
                  cmd.wr_addr     = ptr_ff[IdxW-1:0];
                  cmd.cap_entry   = 1'b1;
                  state_in        = ST_RESP;
               end else begin
                  cmd.cap_entry = 1'b1;
                  if (stat.func == FuncRemove) begin
                     count_in = count_ff - 1'b1;
                     ptr_in   = ptr_ff + 1'b1;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = IdxW'(ptr_ff + 1'b1);
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end else begin
               ptr_in      = ptr_ff + 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = IdxW'(ptr_ff + 1'b1);
            end
         end
         ST_HIT: begin
            status_in     = StatOk;
            slot_in       = ptr_ff[IdxW-1:0];
            cmd.cap_entry = 1'b1;
            state_in      = ST_RESP;
         end
         ST_SHIFT: begin
            // count_ff already decremented: old live count is count_ff + 1
            if (ptr_ff > count_ff) begin
               state_in = ST_RESP;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = IdxW'(ptr_ff - 1'b1);
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            ptr_in      = ptr_ff + 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = IdxW'(ptr_ff + 1'b1);
            state_in    = ST_SHIFT;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth)) else $error("live count above depth");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("input open while word pending");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == StatFull) |-> count_ff == CntW'(Depth))
      else $error("full reported below depth");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> ({1'b0, cmd.wr_addr} <= count_ff)) else $error("write past count");
`endif

endmodule

### hdl/keyed_record_table_top.sv
// Keyed record table: ordered table of up to 256 records keyed by 128 bits.
// Input channel req_*: one word per operation (upsert, remove, find,
// read-at, clear), taken when req_valid is high and req_stall low.
// Result channel rsp_*: exactly one word per operation, held while
// rsp_stall is high. One operation is in flight at a time; req_stall
// stays high from acceptance until the result word is taken, and the
// next word can be taken the cycle after that.
// Clear, unknown codes and a read-at miss go from decode straight to the
// result; a read-at hit first reads its slot. Key operations scan the
// live slots in order, one slot a cycle, through the record RAM (one
// write port, one read port); a remove then moves every later entry
// down one slot, with one read and one write per entry.
// Reset (synchronous) empties the table by zeroing the live count; the
// record RAM itself is not cleared, no clearing pass is needed.
// A stalled result holds the block: no new word is accepted meanwhile.
module keyed_record_table_top import krt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_index,
   input  logic [63:0] req_key_hi,
   input  logic [63:0] req_key_lo,
   input  logic [31:0] req_version,
   input  logic [63:0] req_package_size,
   input  logic [31:0] req_payload_crc,
   input  logic [31:0] req_installed_time,
   input  logic [15:0] req_kind,
   input  logic [15:0] req_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_slot,
   output logic [8:0]  rsp_live_count,
   output logic [63:0] rsp_out_key_hi,
   output logic [63:0] rsp_out_key_lo,
   output logic [31:0] rsp_out_version,
   output logic [63:0] rsp_out_size,
   output logic [31:0] rsp_out_crc,
   output logic [31:0] rsp_out_installed,
   output logic [15:0] rsp_out_kind,
   output logic [15:0] rsp_out_flags
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   entry_type   out_entry;

   krt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_slot, .rsp_live_count, .cmd, .stat
   );

   krt_datapath u_dp (
      .clock, .cmd, .req_func, .req_index, .req_key_hi, .req_key_lo,
      .req_version, .req_package_size, .req_payload_crc,
      .req_installed_time, .req_kind, .req_flags, .stat, .out_entry
   );

   assign rsp_out_key_hi    = out_entry.key_hi;
   assign rsp_out_key_lo    = out_entry.key_lo;
   assign rsp_out_version   = out_entry.version;
   assign rsp_out_size      = out_entry.size;
   assign rsp_out_crc       = out_entry.crc;
   assign rsp_out_installed = out_entry.installed;
   assign rsp_out_kind      = out_entry.kind;
   assign rsp_out_flags     = out_entry.flags;

endmodule

### dv/keyed_record_table_top_tb.sv
module keyed_record_table_top_tb;
   import krt_pkg::*;

   localparam int Items    = 1170;
   localparam int HoldAt   = 200;
   localparam int PauseAt  = 600;
   localparam int FillAt   = 820;
   localparam int PoolSize = 64;
   localparam int CycleCap = 3000000;

   typedef struct {
      logic [2:0]  func;
      logic [7:0]  index;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [31:0] version;
      logic [63:0] size;
      logic [31:0] crc;
      logic [31:0] installed;
      logic [15:0] kind;
      logic [15:0] flags;
   } table_op_type;

   typedef struct {
      logic [1:0] status;
      logic [7:0] slot;
      logic [8:0] count;
      entry_type  ent;
   } table_word_type;

   typedef struct {
      table_op_type op;
      bit           typed;
      logic [1:0]   status;
      logic [7:0]   slot;
      logic [8:0]   count;
   } directed_row_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0]  req_func;
   logic [7:0]  req_index;
   logic [63:0] req_key_hi, req_key_lo, req_package_size;
   logic [31:0] req_version, req_payload_crc, req_installed_time;
   logic [15:0] req_kind, req_flags;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_slot;
   logic [8:0]  rsp_live_count;
   logic [63:0] rsp_out_key_hi, rsp_out_key_lo, rsp_out_size;
   logic [31:0] rsp_out_version, rsp_out_crc, rsp_out_installed;
   logic [15:0] rsp_out_kind, rsp_out_flags;

   // shadow copy of the table
   entry_type   shadow_rec[Depth];
   int unsigned shadow_count;

   table_word_type   pending_words[$];
   directed_row_type directed_rows[$];
   table_op_type     fill_burst[$];
   logic [127:0]     key_pool[PoolSize];

   int  mismatches = 0;
   int  cycles = 0;
   int  recv_pct;
   bit  hold_go;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   keyed_record_table_top uut (.*);

   always #5 clock = ~clock;

   function automatic table_op_type make_op(logic [2:0] f, logic [7:0] ix,
                                            logic [127:0] key, logic [63:0] pat);
      table_op_type op;
      op.func      = f;
      op.index     = ix;
      op.key_hi    = key[127:64];
      op.key_lo    = key[63:0];
      op.version   = pat[31:0];
      op.size      = pat;
      op.crc       = pat[63:32];
      op.installed = pat[31:0];
      op.kind      = pat[15:0];
      op.flags     = pat[63:48];
      return op;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic table_op_type random_op();
      table_op_type op;
      int           pick;
      logic [127:0] key;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) key = {rand64(), rand64()};
      else key = key_pool[$urandom_range(PoolSize - 1)];
      op.func      = pick < 42 ? FuncUpsert : pick < 62 ? FuncRemove :
                     pick < 77 ? FuncFind : pick < 92 ? FuncReadAt :
                     pick < 94 ? FuncClear : 3'($urandom_range(7, 5));
      if (shadow_count != 0 && $urandom_range(9) < 7)
         op.index = 8'($urandom_range(shadow_count - 1));
      else
         op.index = 8'($urandom);
      op.key_hi    = key[127:64];
      op.key_lo    = key[63:0];
      op.version   = $urandom;
      op.size      = rand64();
      op.crc       = $urandom;
      op.installed = $urandom;
      op.kind      = 16'($urandom);
      op.flags     = 16'($urandom);
      return op;
   endfunction

   function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_rec[i].key_hi == hi && shadow_rec[i].key_lo == lo) return i;
      return -1;
   endfunction

   // updates the shadow table and returns the word the block should send
   function automatic table_word_type table_step(table_op_type op);
      table_word_type w;
      int             s;
      w        = '{status: StatMissing, slot: '0, count: '0, ent: '0};
      s        = find_slot(op.key_hi, op.key_lo);
      case (op.func)
         FuncUpsert: begin
            if (s < 0 && shadow_count >= Depth) begin
               w.status = StatFull;
            end else begin
               if (s < 0) begin
                  s = shadow_count;
                  shadow_count++;
               end
               shadow_rec[s] = '{key_hi: op.key_hi, key_lo: op.key_lo,
                                 version: op.version, size: op.size, crc: op.crc,
                                 installed: op.installed, flags: op.flags,
                                 kind: op.kind};
               w.status = StatOk;
               w.slot   = 8'(s);
               w.ent    = shadow_rec[s];
            end
         end
         FuncRemove: begin
            if (s >= 0) begin
               w.ent = shadow_rec[s];
               for (int j = s + 1; j < shadow_count; j++)
                  shadow_rec[j - 1] = shadow_rec[j];
               shadow_count--;
               w.status = StatOk;
               w.slot   = 8'(s);
            end
         end
         FuncFind: begin
            if (s >= 0) begin
               w.ent    = shadow_rec[s];
               w.status = StatOk;
               w.slot   = 8'(s);
            end
         end
         FuncReadAt: begin
            if (op.index < shadow_count) begin
               w.ent    = shadow_rec[op.index];
               w.status = StatOk;
               w.slot   = op.index;
            end
         end
         FuncClear: begin
            shadow_count = 0;
            w.status     = StatOk;
         end
         default: ;
      endcase
      w.count = 9'(shadow_count);
      return w;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %h, got %h", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   task automatic add_row(table_op_type op, bit typed, logic [1:0] st, logic [7:0] sl,
                          logic [8:0] cnt);
      directed_rows.push_back('{op: op, typed: typed, status: st, slot: sl, count: cnt});
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("keyed_record_table_top_tb NOT OK");
         $finish;
      end
   end

   // result side: random stall plus one long hold-off
   always @(posedge clock) begin : result_side
      table_word_type w;
      if (hold_go && !hold_done) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing pending");
            mismatches++;
         end else begin
            w = pending_words.pop_front();
            check_field("status", w.status, rsp_status);
            check_field("slot", w.slot, rsp_slot);
            check_field("live_count", w.count, rsp_live_count);
            check_field("out_key_hi", w.ent.key_hi, rsp_out_key_hi);
            check_field("out_key_lo", w.ent.key_lo, rsp_out_key_lo);
            check_field("out_version", w.ent.version, rsp_out_version);
            check_field("out_size", w.ent.size, rsp_out_size);
            check_field("out_crc", w.ent.crc, rsp_out_crc);
            check_field("out_installed", w.ent.installed, rsp_out_installed);
            check_field("out_kind", w.ent.kind, rsp_out_kind);
            check_field("out_flags", w.ent.flags, rsp_out_flags);
         end
      end
   end

   initial begin : request_side
      table_op_type   cur;
      table_word_type w;
      logic [127:0]   k0, k1, k2;
      int             send_pct;
      bit             typed;
      int             n;
      clock = 0; reset = 1; req_valid = 0;
      req_func = '0; req_index = '0; req_key_hi = '0; req_key_lo = '0;
      req_version = '0; req_package_size = '0; req_payload_crc = '0;
      req_installed_time = '0; req_kind = '0; req_flags = '0;
      recv_pct = 65; hold_go = 0;
      shadow_count = 0; send_pct = 10;

      key_pool[0] = '1;
      key_pool[1] = '0;
      for (int i = 2; i < PoolSize; i++) key_pool[i] = {rand64(), rand64()};
      k0 = key_pool[1]; k1 = key_pool[0]; k2 = key_pool[2];

      add_row(make_op(FuncReadAt, 8'd0, k1, '0), 1, StatMissing, 0, 0);
      add_row(make_op(FuncFind, 8'd0, k1, '0), 1, StatMissing, 0, 0);
      add_row(make_op(FuncRemove, 8'd0, k1, '0), 1, StatMissing, 0, 0);
      add_row(make_op(FuncClear, 8'd0, k1, '0), 1, StatOk, 0, 0);
      add_row(make_op(3'd5, 8'd0, k1, '1), 1, StatMissing, 0, 0);
      add_row(make_op(3'd6, 8'd0, k1, '1), 1, StatMissing, 0, 0);
      add_row(make_op(3'd7, 8'hff, k1, '1), 1, StatMissing, 0, 0);
      add_row(make_op(FuncUpsert, 8'hff, k1, '1), 1, StatOk, 0, 1);
      add_row(make_op(FuncUpsert, 8'd0, k0, '0), 1, StatOk, 1, 2);
      add_row(make_op(FuncUpsert, 8'h55, k2, {4{16'h5555}}), 1, StatOk, 2, 3);
      // same key again overwrites in place
      add_row(make_op(FuncUpsert, 8'haa, k1, {4{16'haaaa}}), 1, StatOk, 0, 3);
      add_row(make_op(FuncFind, 8'd0, k0, '0), 1, StatOk, 1, 3);
      add_row(make_op(FuncReadAt, 8'd2, k0, '0), 1, StatOk, 2, 3);
      add_row(make_op(FuncReadAt, 8'd3, k0, '0), 1, StatMissing, 0, 3);
      add_row(make_op(FuncReadAt, 8'hff, k0, '0), 1, StatMissing, 0, 3);
      add_row(make_op(FuncRemove, 8'd0, k1, '0), 1, StatOk, 0, 2);
      add_row(make_op(FuncReadAt, 8'd0, k1, '0), 1, StatOk, 0, 2);
      add_row(make_op(FuncFind, 8'd0, k1, '0), 1, StatMissing, 0, 2);
      add_row(make_op(FuncRemove, 8'd0, k2, '0), 1, StatOk, 1, 1);
      add_row(make_op(FuncClear, 8'd0, k2, '0), 1, StatOk, 0, 0);
      add_row(make_op(FuncFind, 8'd0, k0, '0), 1, StatMissing, 0, 0);

      // fill to capacity, hit full, overwrite at capacity, longest shift
      fill_burst.push_back(make_op(FuncClear, 8'd0, k0, '0));
      for (int i = 0; i < Depth; i++)
         fill_burst.push_back(make_op(FuncUpsert, 8'(i),
            i < PoolSize ? key_pool[i] : {rand64(), rand64()}, rand64()));
      fill_burst.push_back(make_op(FuncUpsert, 8'd0, {rand64(), rand64()}, rand64()));
      fill_burst.push_back(make_op(FuncUpsert, 8'd0, key_pool[5], rand64()));
      fill_burst.push_back(make_op(FuncReadAt, 8'hff, k0, '0));
      fill_burst.push_back(make_op(FuncRemove, 8'd0, key_pool[0], '0));
      fill_burst.push_back(make_op(FuncReadAt, 8'hff, k0, '0));
      fill_burst.push_back(make_op(FuncReadAt, 8'hfe, k0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < Items; n++) begin
         typed = 0;
         if (n < directed_rows.size()) begin
            cur   = directed_rows[n].op;
            typed = directed_rows[n].typed;
         end else if (n >= FillAt && fill_burst.size() != 0) begin
            cur = fill_burst.pop_front();
         end else begin
            cur = random_op();
         end
         if (n == Items / 3) begin
            send_pct = 65;
            recv_pct <= 10;
         end else if (n == 2 * Items / 3) begin
            send_pct = 0;
            recv_pct <= 0;
         end
         if (n == HoldAt) hold_go <= 1'b1;

         if (n == PauseAt || $urandom_range(99) < send_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
            if (n == PauseAt)
               while (pending_words.size() != 0) @(posedge clock);
            else
               while ($urandom_range(99) < send_pct) @(posedge clock);
         end
         req_func           <= cur.func;
         req_index          <= cur.index;
         req_key_hi         <= cur.key_hi;
         req_key_lo         <= cur.key_lo;
         req_version        <= cur.version;
         req_package_size   <= cur.size;
         req_payload_crc    <= cur.crc;
         req_installed_time <= cur.installed;
         req_kind           <= cur.kind;
         req_flags          <= cur.flags;
         req_valid          <= 1'b1;
         @(posedge clock);
         while (req_stall) @(posedge clock);

         w = table_step(cur);
         if (typed) begin
            w.status = directed_rows[n].status;
            w.slot   = directed_rows[n].slot;
            w.count  = directed_rows[n].count;
         end
         pending_words.push_back(w);
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("keyed_record_table_top_tb OK");
      else
         $display("keyed_record_table_top_tb NOT OK");
      $finish;
   end

endmodule
